[hdl/short_apdu_command_parser_defines.svh]
// Assertion helpers for the short APDU parser.
`ifndef SHORT_APDU_COMMAND_PARSER_DEFINES_SVH
`define SHORT_APDU_COMMAND_PARSER_DEFINES_SVH

// Clocked on clk_i, masked while rst_ni is low.
`define SAPDU_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Clocked on clk_i, also checked during reset.
`define SAPDU_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

[hdl/sapdu_pkg.sv]
package sapdu_pkg;

  localparam int unsigned HdrBytes = 4;
  localparam logic [8:0]  LeZeroVal = 9'd256;

  typedef struct packed {
    logic [7:0] byte_in;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic       data_valid;
    logic [7:0] data_byte;
    logic       done_res;
    logic       ok;
    logic [7:0] class_byte;
    logic [7:0] instruction;
    logic [7:0] param_one;
    logic [7:0] param_two;
    logic       has_length_command;
    logic [7:0] length_command;
    logic       has_length_expected;
    logic [8:0] length_expected;
  } out_item_t;

endpackage

[hdl/short_apdu_command_parser.sv]
// Short command APDU parser: one byte per transfer, one result per byte.
// Path: each byte is registered in the input register, then its result is
//   registered in the result register; out_stall_i holds the result there
//   and, once both registers are full, stalls the input side.
// Throughput: one byte per cycle while the output side takes results.
// Reset: rst_ni async active low; clears both register valids and returns
//   the parser to the header phase with Lc/Le flags clear.
module short_apdu_command_parser (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  sapdu_pkg::in_item_t  in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output sapdu_pkg::out_item_t out_data_o
);
  import sapdu_pkg::*;

  // Input register stage
  logic      in_vld_q;
  in_item_t  in_q;
  // Result register stage
  logic      out_vld_q;
  out_item_t out_q;

  logic      res_ready;   // result register can take a new result
  logic      fire;        // byte in the input register is parsed this cycle
  out_item_t res;

  // Result register frees up when empty or when its transfer completes.
  assign res_ready  = !out_vld_q || !out_stall_i;
  assign fire       = in_vld_q && res_ready;
  // Input side stalls only when the input register holds a byte that
  // cannot move on this cycle.
  assign in_stall_o = in_vld_q && !res_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_valid_i && !in_stall_o) begin
      in_vld_q <= 1'b1;
    end else if (fire) begin
      in_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      in_q <= in_data_i;
    end
  end

  // Phase tracking, header capture and result formation
  sapdu_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (fire),
    .item_i (in_q),
    .res_o  (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (fire) begin
      out_vld_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

endmodule

[hdl/sapdu_core.sv]
// Parse state and per-byte result logic.
module sapdu_core (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 fire_i,
  input  sapdu_pkg::in_item_t  item_i,
  output sapdu_pkg::out_item_t res_o
);
  import sapdu_pkg::*;

  localparam logic [2:0] PH_HEADER = 3'd0;
  localparam logic [2:0] PH_LEN5   = 3'd1;
  localparam logic [2:0] PH_DATA   = 3'd2;
  localparam logic [2:0] PH_LE     = 3'd3;
  localparam logic [2:0] PH_TAIL   = 3'd4;

  logic [2:0] phase_q, phase_d;
  logic [2:0] hidx_q, hidx_d;
  logic [7:0] rem_q, rem_d;
  logic [7:0] hdr_q [HdrBytes];
  logic [7:0] hdr_d [HdrBytes];
  logic       lc_has_q, lc_has_d;
  logic [7:0] lc_q, lc_d;
  logic       le_has_q, le_has_d;
  logic [8:0] le_q, le_d;
  logic       ok;
  logic       dvalid;
  logic [8:0] le_of_byte;
  logic [7:0] b;
  logic       last;

  assign b          = item_i.byte_in;
  assign last       = item_i.last_byte;
  assign le_of_byte = (b == 8'd0) ? LeZeroVal : {1'b0, b};

  always_comb begin
    phase_d  = phase_q;
    hidx_d   = hidx_q;
    rem_d    = rem_q;
    hdr_d    = hdr_q;
    lc_has_d = lc_has_q;
    lc_d     = lc_q;
    le_has_d = le_has_q;
    le_d     = le_q;
    ok       = 1'b1;
    dvalid   = 1'b0;
    unique case (phase_q)
      PH_HEADER: begin
        hdr_d[hidx_q[1:0]] = b;
        hidx_d = hidx_q + 3'd1;
        if (hidx_q == 3'd3) begin
          phase_d = PH_LEN5;
        end else if (last) begin
          ok = 1'b0;
        end
      end
      PH_LEN5: begin
        if (last) begin
          le_has_d = 1'b1;
          le_d     = le_of_byte;
        end else begin
          lc_has_d = 1'b1;
          lc_d     = b;
          rem_d    = b;
          phase_d  = (b == 8'd0) ? PH_LE : PH_DATA;
        end
      end
      PH_DATA: begin
        dvalid = 1'b1;
        rem_d  = rem_q - 8'd1;
        if (rem_q == 8'd1) begin
          phase_d = PH_LE;
        end else if (last) begin
          ok = 1'b0;
        end
      end
      PH_LE: begin
        le_has_d = 1'b1;
        le_d     = le_of_byte;
        phase_d  = PH_TAIL;
      end
      default: begin
        // trailing bytes and unused codes: nothing to do
      end
    endcase
  end

  // Summary fields only on a good last byte; lengths gated by their flags.
  always_comb begin
    res_o                     = '0;
    res_o.data_valid          = dvalid;
    res_o.data_byte           = dvalid ? b : 8'd0;
    res_o.done_res            = last;
    if (last && ok) begin
      res_o.ok                  = 1'b1;
      res_o.class_byte          = hdr_d[0];
      res_o.instruction         = hdr_d[1];
      res_o.param_one           = hdr_d[2];
      res_o.param_two           = hdr_d[3];
      res_o.has_length_command  = lc_has_d;
      res_o.length_command      = lc_has_d ? lc_d : 8'd0;
      res_o.has_length_expected = le_has_d;
      res_o.length_expected     = le_has_d ? le_d : 9'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_HEADER;
      hidx_q   <= 3'd0;
      rem_q    <= 8'd0;
      lc_has_q <= 1'b0;
      le_has_q <= 1'b0;
    end else if (fire_i) begin
      if (last) begin
        phase_q  <= PH_HEADER;
        hidx_q   <= 3'd0;
        rem_q    <= 8'd0;
        lc_has_q <= 1'b0;
        le_has_q <= 1'b0;
      end else begin
        phase_q  <= phase_d;
        hidx_q   <= hidx_d;
        rem_q    <= rem_d;
        lc_has_q <= lc_has_d;
        le_has_q <= le_has_d;
      end
    end
  end

  // Payload: header bytes and length values, read only behind their flags
  // or after being written in the current command.
  always_ff @(posedge clk_i) begin
    if (fire_i) begin
      hdr_q <= hdr_d;
      lc_q  <= lc_d;
      le_q  <= le_d;
    end
  end

endmodule

[hdl/sapdu_checker.sv]
`include "short_apdu_command_parser_defines.svh"

module sapdu_checker (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 in_valid_i,
  input logic                 in_stall_o,
  input sapdu_pkg::in_item_t  in_data_i,
  input logic                 out_valid_o,
  input logic                 out_stall_i,
  input sapdu_pkg::out_item_t out_data_o
);
  import sapdu_pkg::*;

  `SAPDU_ASSERT(a_out_hold, out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o), "stalled result changed")
  `SAPDU_ASSERT(a_ok_needs_done, out_valid_o && out_data_o.ok |-> out_data_o.done_res, "ok without done")
  `SAPDU_ASSERT(a_bad_zero, out_valid_o && !out_data_o.ok |-> !out_data_o.has_length_command && !out_data_o.has_length_expected && out_data_o.class_byte == 8'd0 && out_data_o.length_expected == 9'd0, "summary not cleared")
  `SAPDU_ASSERT(a_le_nonzero, out_valid_o && out_data_o.has_length_expected |-> out_data_o.length_expected != 9'd0, "Le flagged with zero length")
  `SAPDU_ASSERT_ALWAYS(a_rst_idle, !rst_ni |=> !out_valid_o, "result valid in reset")

endmodule

bind short_apdu_command_parser sapdu_checker u_sapdu_checker (.*);

[sim/short_apdu_command_parser_tb.sv]
module short_apdu_command_parser_tb;
  import sapdu_pkg::*;

  // Stimulus volume and timing knobs
  localparam int unsigned ItemTarget    = 700;
  localparam int unsigned HoldCycles    = 200;   // long receiver hold-off
  localparam int unsigned DrainCycles   = 10;    // margin after the scoreboard drains
  localparam int unsigned WatchdogLimit = 2000;  // cycles with no transfer at all
  localparam int unsigned ReportLimit   = 10;

  // Parser phases, tracked by the scoreboard's own copy of the state
  typedef enum logic [2:0] {
    PH_HEADER,
    PH_LC_OR_LE,
    PH_DATA,
    PH_LE,
    PH_TAIL
  } apdu_phase_e;

  // Receiver backpressure styles
  typedef enum int unsigned {
    STALL_NONE,
    STALL_LIGHT,
    STALL_HALF,
    STALL_HEAVY
  } stall_mode_e;

  typedef logic [7:0] apdu_bytes_t [$];

  // Scoreboard: predicts one result per accepted byte and checks results in order.
  class apdu_scoreboard;
    apdu_phase_e phase;
    logic [2:0]  hdr_count;
    logic [7:0]  data_left;
    logic [7:0]  hdr [HdrBytes];
    logic        lc_seen;
    logic [7:0]  lc_val;
    logic        le_seen;
    logic [8:0]  le_val;
    out_item_t   expected_q [$];
    int unsigned errors;
    int unsigned results_seen;

    function new();
      errors       = 0;
      results_seen = 0;
      clear_command();
    endfunction

    function void clear_command();
      phase     = PH_HEADER;
      hdr_count = '0;
      data_left = '0;
      foreach (hdr[i]) hdr[i] = '0;
      lc_seen   = 1'b0;
      lc_val    = '0;
      le_seen   = 1'b0;
      le_val    = '0;
    endfunction

    // Le byte of zero stands for 256
    function logic [8:0] le_value(logic [7:0] b);
      return (b == 8'd0) ? LeZeroVal : {1'b0, b};
    endfunction

    function void note_failure(string msg);
      errors++;
      if (errors <= ReportLimit) $display("%s", msg);
    endfunction

    function void note_transfer(in_item_t it);
      out_item_t r;
      logic      good;
      r    = '0;
      good = 1'b1;
      case (phase)
        PH_HEADER: begin
          hdr[hdr_count[1:0]] = it.byte_in;
          hdr_count = hdr_count + 3'd1;
          if (hdr_count >= 3'd4) phase = PH_LC_OR_LE;
          else if (it.last_byte) good = 1'b0;   // fewer than four bytes
        end
        PH_LC_OR_LE: begin
          if (it.last_byte) begin
            // fifth byte that ends the command is Le
            le_seen = 1'b1;
            le_val  = le_value(it.byte_in);
          end else begin
            lc_seen   = 1'b1;
            lc_val    = it.byte_in;
            data_left = it.byte_in;
            phase     = (it.byte_in == 8'd0) ? PH_LE : PH_DATA;
          end
        end
        PH_DATA: begin
          r.data_valid = 1'b1;
          r.data_byte  = it.byte_in;
          data_left    = data_left - 8'd1;
          if (data_left == 8'd0) phase = PH_LE;
          else if (it.last_byte) good = 1'b0;   // truncated data
        end
        PH_LE: begin
          le_seen = 1'b1;
          le_val  = le_value(it.byte_in);
          phase   = PH_TAIL;
        end
        default: ;  // trailing bytes are ignored
      endcase
      if (it.last_byte) begin
        r.done_res = 1'b1;
        if (good) begin
          r.ok                  = 1'b1;
          r.class_byte          = hdr[0];
          r.instruction         = hdr[1];
          r.param_one           = hdr[2];
          r.param_two           = hdr[3];
          r.has_length_command  = lc_seen;
          r.length_command      = lc_val;
          r.has_length_expected = le_seen;
          r.length_expected     = le_val;
        end
        clear_command();
      end
      expected_q.push_back(r);
    endfunction

    function void diff(string field, logic [8:0] want, logic [8:0] got);
      if (got !== want)
        note_failure($sformatf("result %0d: %s expected 0x%0h got 0x%0h",
                               results_seen, field, want, got));
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      results_seen++;
      if (expected_q.size() == 0) begin
        note_failure($sformatf("result %0d: no result expected", results_seen));
        return;
      end
      want = expected_q.pop_front();
      diff("data_valid", want.data_valid, got.data_valid);
      diff("data_byte", want.data_byte, got.data_byte);
      diff("done_res", want.done_res, got.done_res);
      diff("ok", want.ok, got.ok);
      diff("class_byte", want.class_byte, got.class_byte);
      diff("instruction", want.instruction, got.instruction);
      diff("param_one", want.param_one, got.param_one);
      diff("param_two", want.param_two, got.param_two);
      diff("has_length_command", want.has_length_command, got.has_length_command);
      diff("length_command", want.length_command, got.length_command);
      diff("has_length_expected", want.has_length_expected, got.has_length_expected);
      diff("length_expected", want.length_expected, got.length_expected);
    endfunction
  endclass

  // Everything the block sees is known from time zero.
  logic      clk_i       = 1'b0;
  logic      rst_ni      = 1'b0;
  logic      in_valid_i  = 1'b0;
  in_item_t  in_data_i   = '0;
  logic      out_stall_i = 1'b0;
  logic      in_stall_o;
  logic      out_valid_o;
  out_item_t out_data_o;

  apdu_scoreboard sb;
  int unsigned    sent_bytes  = 0;
  int unsigned    burst_left  = 0;
  int unsigned    idle_cycles = 0;
  bit             hold_req    = 1'b0;  // asks the receiver for one long hold-off

  short_apdu_command_parser DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Offer one byte and hold it until the transfer happens. The sender works
  // in bursts; a new burst may start after a gap with valid low.
  task automatic send_byte(in_item_t it);
    int unsigned gap;
    if (burst_left == 0) begin
      // mostly short bursts, some long stretches with no idling
      burst_left = ($urandom_range(3) == 0) ? $urandom_range(60, 20) : $urandom_range(12, 1);
      gap = $urandom_range(6);
      if (gap != 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    in_valid_i <= 1'b1;
    in_data_i  <= it;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    sent_bytes++;
  endtask

  // One command: last_byte marks its final byte.
  task automatic send_cmd(apdu_bytes_t bytes);
    in_item_t it;
    foreach (bytes[i]) begin
      it.byte_in   = bytes[i];
      it.last_byte = (i == bytes.size() - 1);
      send_byte(it);
    end
  endtask

  // Sender goes quiet until every expected result has come back.
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.expected_q.size() != 0) @(posedge clk_i);
  endtask

  // Random command shapes: mostly well-formed, with short, truncated and
  // plain noise commands mixed in.
  function automatic apdu_bytes_t random_command();
    apdu_bytes_t q;
    int unsigned pick, lc, keep, tail;
    pick = $urandom_range(99);
    repeat (4) q.push_back(8'($urandom));
    if (pick < 8) begin
      // too short: one to three bytes
      keep = $urandom_range(3, 1);
      while (q.size() > keep) void'(q.pop_back());
    end else if (pick < 16) begin
      // header only
    end else if (pick < 28) begin
      // header and Le; favor the zero case now and then
      q.push_back(($urandom_range(4) == 0) ? 8'h00 : 8'($urandom));
    end else if (pick < 94) begin
      lc = ($urandom_range(39) == 0) ? $urandom_range(255, 128) : $urandom_range(8);
      q.push_back(8'(lc));
      if (pick < 40 && lc >= 2) begin
        // truncated: last byte lands on a data byte before the end
        repeat ($urandom_range(lc - 1, 1)) q.push_back(8'($urandom));
      end else begin
        repeat (lc) q.push_back(8'($urandom));
        tail = $urandom_range(3);
        if (tail != 0) q.push_back(($urandom_range(4) == 0) ? 8'h00 : 8'($urandom));
        if (tail == 2) repeat ($urandom_range(3, 1)) q.push_back(8'($urandom));
      end
    end else begin
      // noise of random length
      repeat ($urandom_range(8)) q.push_back(8'($urandom));
    end
    return q;
  endfunction

  // Receiver backpressure: picks a new style for each span of random length. A
  // hold-off request is served here, counted in this process, while the sender
  // keeps offering bytes so that the block fills up and stalls its input.
  initial begin : result_stall_gen
    stall_mode_e mode;
    int unsigned span;
    forever begin
      mode = stall_mode_e'($urandom_range(3));
      span = $urandom_range(80, 10);
      repeat (span) begin
        if (hold_req) begin
          out_stall_i <= 1'b1;
          repeat (HoldCycles) @(posedge clk_i);
          hold_req = 1'b0;
        end
        case (mode)
          STALL_NONE:  out_stall_i <= 1'b0;
          STALL_LIGHT: out_stall_i <= ($urandom_range(3) == 0);
          STALL_HALF:  out_stall_i <= 1'($urandom_range(1));
          default:     out_stall_i <= ($urandom_range(7) != 0);
        endcase
        @(posedge clk_i);
      end
    end
  end

  // Transfer monitor and watchdog. Values read here are the ones from before
  // the edge, since every driver uses nonblocking updates.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) sb.note_transfer(in_data_i);
      if (out_valid_o && !out_stall_i) sb.check_result(out_data_o);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WatchdogLimit) begin
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  initial begin : stimulus
    apdu_bytes_t q;
    bit          held;
    bit          paused;
    sb     = new();
    held   = 1'b0;
    paused = 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: single byte command (too short)
    q = '{8'hFF};
    send_cmd(q);
    // header only, extremes in the header bytes
    q = '{8'h00, 8'hFF, 8'h80, 8'h7F};
    send_cmd(q);
    // header plus Le of zero, read as 256
    q = '{8'h01, 8'h02, 8'h03, 8'h04, 8'h00};
    send_cmd(q);
    // Lc of zero, then Le, then a trailing byte that is ignored
    q = '{8'hFF, 8'hFE, 8'hFD, 8'hFC, 8'h00, 8'hFF, 8'h7E};
    send_cmd(q);
    // two data bytes, command ends on the last data byte
    q = '{8'h80, 8'hCA, 8'h00, 8'h01, 8'h02, 8'hFF, 8'h00};
    send_cmd(q);
    // truncated data: Lc of three, only one data byte
    q = '{8'h11, 8'h22, 8'h33, 8'h44, 8'h03, 8'hAA};
    send_cmd(q);

    // Random commands
    while (sent_bytes < ItemTarget) begin
      q = random_command();
      send_cmd(q);
      if (!held && sent_bytes > 200) begin
        held     = 1'b1;
        hold_req = 1'b1;
      end
      if (!paused && sent_bytes > 450) begin
        paused = 1'b1;
        wait_drained();
      end
    end

    wait_drained();
    repeat (DrainCycles) @(posedge clk_i);
    if (sb.expected_q.size() != 0)
      sb.note_failure($sformatf("%0d results never arrived", sb.expected_q.size()));
    if (sb.errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
